/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a condition implies another condition in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies another condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/fcpt_pkg.sv */
package fcpt_pkg;

   localparam int unsigned REQ_IDX_W = 9;
   localparam int unsigned USED_OUT_W = 10;
   localparam int unsigned ADDR_W = 32;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ENTER = 2'd1,
      OP_EXIT  = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_DISABLED = 2'd1,
      ST_FULL     = 2'd2,
      ST_UNUSED   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FETCH,
      FSM_UPDATE,
      FSM_RESP
   } fsm_type;

   localparam logic [0:0] REG_ENABLE = 1'b0;

endpackage

/* rtl/function_call_profile_table_top.sv */
// Function entry/exit profiler. Each req_ transaction is one event (clear
// and start, function entry, function exit, or read of one table entry) and
// produces exactly one rsp_ transaction with a status, the touched entry's
// address, call count and run time, the number of allocated entries and the
// time since the last clear. Function addresses live in a single-port-read
// synchronous memory that is searched one entry per cycle, so an entry or
// exit event scans the allocated entries in turn; a miss that allocates or
// a hit on the last entry is the longest case. Clear and read do not scan,
// and any event may also wait for rsp_ready. No clearing pass follows
// reset: entries count as allocated only below the fill count, which reset
// and clear zero. Write the enable register (byte address 0, bit 0) only
// while no event is in flight.
module function_call_profile_table_top
   import fcpt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 512,
   parameter int unsigned TIME_WIDTH  = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [31:0]           req_func_addr,
   input  logic [31:0]           req_timestamp,
   input  logic [REQ_IDX_W-1:0]  req_read_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [31:0]           rsp_entry_func,
   output logic [31:0]           rsp_entry_calls,
   output logic [31:0]           rsp_entry_run_time,
   output logic [USED_OUT_W-1:0] rsp_used_entries,
   output logic [31:0]           rsp_elapsed
);

   // entry index, fill count and per-entry data word widths
   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned DW    = 33 + 2 * TIME_WIDTH;

   logic              enable;
   logic              set_enable;
   logic              fn_we, fn_re, dt_we, dt_re;
   logic [IDX_W-1:0]  fn_waddr, fn_raddr, dt_waddr, dt_raddr;
   logic [ADDR_W-1:0] fn_wdata, fn_rdata;
   logic [DW-1:0]     dt_wdata, dt_rdata;

   // register port: enable bit, set again by every clear transaction
   fcpt_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .set_enable (set_enable),
      .enable     (enable)
   );

   // address memory and per-entry data memory {running, calls, run time, entry time}
   fcpt_store #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W),
      .DW    (DW)
   ) u_store (
      .clock    (clock),
      .fn_we    (fn_we),
      .fn_waddr (fn_waddr),
      .fn_wdata (fn_wdata),
      .fn_re    (fn_re),
      .fn_raddr (fn_raddr),
      .fn_rdata (fn_rdata),
      .dt_we    (dt_we),
      .dt_waddr (dt_waddr),
      .dt_wdata (dt_wdata),
      .dt_re    (dt_re),
      .dt_raddr (dt_raddr),
      .dt_rdata (dt_rdata)
   );

   // sequencer: scan, fetch, read-modify-write, hold result in the output register
   fcpt_engine #(
      .DEPTH (TABLE_DEPTH),
      .TW    (TIME_WIDTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .DW    (DW)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .enable             (enable),
      .set_enable         (set_enable),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_func_addr      (req_func_addr),
      .req_timestamp      (req_timestamp),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_entry_func     (rsp_entry_func),
      .rsp_entry_calls    (rsp_entry_calls),
      .rsp_entry_run_time (rsp_entry_run_time),
      .rsp_used_entries   (rsp_used_entries),
      .rsp_elapsed        (rsp_elapsed),
      .fn_we              (fn_we),
      .fn_waddr           (fn_waddr),
      .fn_wdata           (fn_wdata),
      .fn_re              (fn_re),
      .fn_raddr           (fn_raddr),
      .fn_rdata           (fn_rdata),
      .dt_we              (dt_we),
      .dt_waddr           (dt_waddr),
      .dt_wdata           (dt_wdata),
      .dt_re              (dt_re),
      .dt_raddr           (dt_raddr),
      .dt_rdata           (dt_rdata)
   );

endmodule

/* rtl/fcpt_csr.sv */
module fcpt_csr
   import fcpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   input  logic        set_enable,
   output logic        enable
);

   logic enable_ff;
   logic enable_in;
   logic wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ENABLE) && (paddr[1:0] == 2'b00);

   always_comb begin
      enable_in = enable_ff;
      if (wr_hit) begin
         enable_in = pwdata[0];
      end
      // a clear transaction turns recording on
      if (set_enable) begin
         enable_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   assign enable = enable_ff;
   assign prdata = (paddr == 3'b000) ? {31'b0, enable_ff} : 32'b0;

endmodule

/* rtl/fcpt_store.sv */
module fcpt_store
   import fcpt_pkg::*;
#(
   parameter int unsigned DEPTH = 512,
   parameter int unsigned IDX_W = 9,
   parameter int unsigned DW    = 97
)
(
   input  logic              clock,
   input  logic              fn_we,
   input  logic [IDX_W-1:0]  fn_waddr,
   input  logic [ADDR_W-1:0] fn_wdata,
   input  logic              fn_re,
   input  logic [IDX_W-1:0]  fn_raddr,
   output logic [ADDR_W-1:0] fn_rdata,
   input  logic              dt_we,
   input  logic [IDX_W-1:0]  dt_waddr,
   input  logic [DW-1:0]     dt_wdata,
   input  logic              dt_re,
   input  logic [IDX_W-1:0]  dt_raddr,
   output logic [DW-1:0]     dt_rdata
);

   logic [ADDR_W-1:0] fn_mem [DEPTH];
   logic [DW-1:0]     dt_mem [DEPTH];
   logic [ADDR_W-1:0] fn_rdata_ff;
   logic [DW-1:0]     dt_rdata_ff;

   always_ff @(posedge clock) begin
      if (fn_we) begin
         fn_mem[fn_waddr] <= fn_wdata;
      end
      if (fn_re) begin
         fn_rdata_ff <= fn_mem[fn_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dt_we) begin
         dt_mem[dt_waddr] <= dt_wdata;
      end
      if (dt_re) begin
         dt_rdata_ff <= dt_mem[dt_raddr];
      end
   end

   assign fn_rdata = fn_rdata_ff;
   assign dt_rdata = dt_rdata_ff;

endmodule

/* rtl/fcpt_engine.sv */
`include "assert_macros.svh"

module fcpt_engine
   import fcpt_pkg::*;
#(
   parameter int unsigned DEPTH  = 512,
   parameter int unsigned TW     = 32,
   parameter int unsigned IDX_W  = 9,
   parameter int unsigned CNT_W  = 10,
   parameter int unsigned DW     = 97
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   output logic                  set_enable,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [31:0]           req_func_addr,
   input  logic [31:0]           req_timestamp,
   input  logic [REQ_IDX_W-1:0]  req_read_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [31:0]           rsp_entry_func,
   output logic [31:0]           rsp_entry_calls,
   output logic [31:0]           rsp_entry_run_time,
   output logic [USED_OUT_W-1:0] rsp_used_entries,
   output logic [31:0]           rsp_elapsed,
   output logic                  fn_we,
   output logic [IDX_W-1:0]      fn_waddr,
   output logic [ADDR_W-1:0]     fn_wdata,
   output logic                  fn_re,
   output logic [IDX_W-1:0]      fn_raddr,
   input  logic [ADDR_W-1:0]     fn_rdata,
   output logic                  dt_we,
   output logic [IDX_W-1:0]      dt_waddr,
   output logic [DW-1:0]         dt_wdata,
   output logic                  dt_re,
   output logic [IDX_W-1:0]      dt_raddr,
   input  logic [DW-1:0]         dt_rdata
);

   fsm_type           state_ff, state_in;
   opcode_type        op_ff, op_in;
   logic [31:0]       addr_ff, addr_in;
   logic [TW-1:0]     now_ff, now_in;
   logic [TW-1:0]     start_ff, start_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              alloc_ff, alloc_in;
   status_type        res_status_ff, res_status_in;
   logic [31:0]       res_func_ff, res_func_in;
   logic [31:0]       res_calls_ff, res_calls_in;
   logic [31:0]       res_run_ff, res_run_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [31:0]       rsp_func_ff, rsp_calls_ff, rsp_run_ff, rsp_elapsed_ff;
   logic [USED_OUT_W-1:0] rsp_used_ff;
   logic              rsp_load;

   logic [63:0]       ts_ext;
   logic [31:0]       ridx_ext;
   logic [31:0]       used_ext;
   logic              hit;
   logic              old_run_flag;
   logic [31:0]       old_calls;
   logic [TW-1:0]     old_run, old_enter;
   logic [TW-1:0]     new_run, new_enter;
   logic [31:0]       new_calls;
   logic              new_flag;
   logic [TW-1:0]     elapsed_t;

   assign ts_ext   = 64'(req_timestamp);
   assign ridx_ext = 32'(req_read_index);
   assign used_ext = 32'(used_ff);
   assign hit      = pend_ff && (fn_rdata == addr_ff);
   assign rsp_load = (state_ff == FSM_RESP) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == FSM_IDLE);

   always_comb begin
      if (alloc_ff) begin
         old_run_flag = 1'b0;
         old_calls    = 32'b0;
         old_run      = '0;
         old_enter    = '0;
      end else begin
         old_run_flag = dt_rdata[DW-1];
         old_calls    = dt_rdata[DW-2 -: 32];
         old_run      = dt_rdata[2*TW-1 -: TW];
         old_enter    = dt_rdata[TW-1:0];
      end
      new_run = old_run_flag ? (old_run + (now_ff - old_enter)) : old_run;
      if (op_ff == OP_ENTER) begin
         new_enter = now_ff;
         new_flag  = 1'b1;
         new_calls = old_calls + 32'd1;
      end else begin
         new_enter = '0;
         new_flag  = 1'b0;
         new_calls = old_calls;
      end
   end

   assign elapsed_t = now_ff - start_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      now_in        = now_ff;
      start_in      = start_ff;
      used_in       = used_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pidx_in       = pidx_ff;
      idx_in        = idx_ff;
      alloc_in      = alloc_ff;
      res_status_in = res_status_ff;
      res_func_in   = res_func_ff;
      res_calls_in  = res_calls_ff;
      res_run_in    = res_run_ff;
      set_enable    = 1'b0;
      fn_we         = 1'b0;
      fn_waddr      = idx_ff;
      fn_wdata      = addr_ff;
      fn_re         = 1'b0;
      fn_raddr      = idx_ff;
      dt_we         = 1'b0;
      dt_waddr      = idx_ff;
      dt_wdata      = {new_flag, new_calls, new_run, new_enter};
      dt_re         = 1'b0;
      dt_raddr      = idx_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               op_in         = opcode_type'(req_opcode);
               addr_in       = req_func_addr;
               now_in        = ts_ext[TW-1:0];
               idx_in        = ridx_ext[IDX_W-1:0];
               scan_in       = '0;
               pend_in       = 1'b0;
               alloc_in      = 1'b0;
               res_status_in = ST_DONE;
               res_func_in   = 32'b0;
               res_calls_in  = 32'b0;
               res_run_in    = 32'b0;
               case (opcode_type'(req_opcode))
                  OP_CLEAR: begin
                     used_in    = '0;
                     start_in   = ts_ext[TW-1:0];
                     set_enable = 1'b1;
                     state_in   = FSM_RESP;
                  end
                  OP_READ: begin
                     if ((ridx_ext < used_ext) && (ridx_ext < DEPTH)) begin
                        state_in = FSM_FETCH;
                     end else begin
                        res_status_in = ST_UNUSED;
                        state_in      = FSM_RESP;
                     end
                  end
                  default: begin
                     if (enable) begin
                        state_in = FSM_SCAN;
                     end else begin
                        res_status_in = ST_DISABLED;
                        state_in      = FSM_RESP;
                     end
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            if (hit) begin
               idx_in   = pidx_ff;
               state_in = FSM_FETCH;
            end else if (scan_ff < used_ff) begin
               fn_re    = 1'b1;
               fn_raddr = scan_ff[IDX_W-1:0];
               pend_in  = 1'b1;
               pidx_in  = scan_ff[IDX_W-1:0];
               scan_in  = scan_ff + CNT_W'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else if (used_ff == CNT_W'(DEPTH)) begin
               res_status_in = ST_FULL;
               state_in      = FSM_RESP;
            end else begin
               idx_in   = used_ff[IDX_W-1:0];
               alloc_in = 1'b1;
               state_in = FSM_UPDATE;
            end
         end
         FSM_FETCH: begin
            fn_re    = 1'b1;
            dt_re    = 1'b1;
            state_in = FSM_UPDATE;
         end
         FSM_UPDATE: begin
            if (op_ff == OP_READ) begin
               res_func_in  = fn_rdata;
               res_calls_in = dt_rdata[DW-2 -: 32];
               res_run_in   = 64'(dt_rdata[2*TW-1 -: TW]) >> 0 == 64'b0 ? 32'b0
                              : 32'(64'(dt_rdata[2*TW-1 -: TW]));
            end else begin
               dt_we        = 1'b1;
               fn_we        = alloc_ff;
               res_func_in  = addr_ff;
               res_calls_in = new_calls;
               res_run_in   = 32'(64'(new_run));
               if (alloc_ff) begin
                  used_in = used_ff + CNT_W'(1);
               end
            end
            state_in = FSM_RESP;
         end
         FSM_RESP: begin
            if (rsp_load) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         used_ff      <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         alloc_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         alloc_ff     <= alloc_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      pidx_ff       <= pidx_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_func_ff   <= res_func_in;
      res_calls_ff  <= res_calls_in;
      res_run_ff    <= res_run_in;
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_func_ff    <= res_func_ff;
         rsp_calls_ff   <= res_calls_ff;
         rsp_run_ff     <= res_run_ff;
         rsp_used_ff    <= USED_OUT_W'(used_ff);
         rsp_elapsed_ff <= 32'(64'(elapsed_t));
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_func     = rsp_func_ff;
   assign rsp_entry_calls    = rsp_calls_ff;
   assign rsp_entry_run_time = rsp_run_ff;
   assign rsp_used_entries   = rsp_used_ff;
   assign rsp_elapsed        = rsp_elapsed_ff;

   `ASSERT_IMPLIES(a_used_bound, clock, reset, 1'b1, used_ff <= CNT_W'(DEPTH))
   `ASSERT_NEXT(a_alloc_count, clock, reset, (state_ff == FSM_UPDATE) && alloc_ff, used_ff == $past(used_ff) + CNT_W'(1))
   `ASSERT_NEXT(a_load_idle, clock, reset, rsp_load, (state_ff == FSM_IDLE) && rsp_valid_ff)

endmodule
